>>> rtl/stoch_pkg.sv
// stochastic oscillator: shared types and fixed constants
// no dependencies; imported by every module of the block

package stoch_pkg;

    localparam int unsigned PCT_W      = 23;
    localparam int unsigned FRAC_W     = 16;
    localparam int unsigned PCT_SCALE  = 100;
    localparam int unsigned SCALE_W    = 7;
    localparam int unsigned DIV_STEPS  = 23;
    localparam int unsigned DIV_CNT_W  = 5;
    localparam int unsigned IN_FIELD_W = 32;
    localparam int unsigned IN_DATA_W  = 96;
    localparam int unsigned OUT_DATA_W = 48;
    localparam int unsigned OUT_USER_W = 3;

    localparam logic [PCT_W-1:0] K_FULL_SCALE = 23'd6553600;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PREP,
        ST_MUL,
        ST_KDIV,
        ST_KUPD,
        ST_DAVG,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

>>> rtl/stoch_cell.sv
// stochastic oscillator: one window cell holding a bar's high and low
// passes its bar and a running min/max on to the next cell; uses stoch_pkg

module stoch_cell
    import stoch_pkg::*;
#(
    parameter int unsigned PRICE_BITS = 32
)
(
    input  logic                  clk,
    input  logic                  shift_en,
    input  logic [PRICE_BITS-1:0] high_in,
    input  logic [PRICE_BITS-1:0] low_in,
    input  logic [PRICE_BITS-1:0] min_in,
    input  logic [PRICE_BITS-1:0] max_in,
    output logic [PRICE_BITS-1:0] high_q,
    output logic [PRICE_BITS-1:0] low_q,
    output logic [PRICE_BITS-1:0] min_q,
    output logic [PRICE_BITS-1:0] max_q
);

    logic [PRICE_BITS-1:0] high_reg;
    logic [PRICE_BITS-1:0] low_reg;
    logic [PRICE_BITS-1:0] min_reg;
    logic [PRICE_BITS-1:0] max_reg;
    logic [PRICE_BITS-1:0] min_next;
    logic [PRICE_BITS-1:0] max_next;

    assign min_next = (low_reg < min_in) ? low_reg : min_in;
    assign max_next = (high_reg > max_in) ? high_reg : max_in;

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            high_reg <= high_in;
            low_reg  <= low_in;
        end
        min_reg <= min_next;
        max_reg <= max_next;
    end

    assign high_q = high_reg;
    assign low_q  = low_reg;
    assign min_q  = min_reg;
    assign max_q  = max_reg;

endmodule

>>> rtl/stoch_div.sv
// stochastic oscillator: restoring divider, one quotient bit per cycle
// quotient below 2^23 assumed, so the remainder is seeded; uses stoch_pkg

module stoch_div
    import stoch_pkg::*;
#(
    parameter int unsigned DEN_W = 32
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DEN_W-1:0] init_rem,
    input  logic [PCT_W-1:0] dividend_lo,
    input  logic [DEN_W-1:0] den,
    output div_stat_t        stat,
    output logic [PCT_W-1:0] quotient
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DEN_W-1:0]     rem_reg;
    logic [DEN_W-1:0]     den_reg;
    logic [PCT_W-1:0]     lo_reg;
    logic [PCT_W-1:0]     q_reg;
    logic [DEN_W:0]       trial;
    logic                 fits;
    logic                 last_step;

    assign trial     = {rem_reg, lo_reg[PCT_W-1]};
    assign fits      = trial >= {1'b0, den_reg};
    assign last_step = cnt_reg == DIV_CNT_W'(DIV_STEPS - 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && last_step;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (last_step)
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= init_rem;
            lo_reg  <= dividend_lo;
            den_reg <= den;
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? DEN_W'(trial - {1'b0, den_reg}) : DEN_W'(trial);
            lo_reg  <= {lo_reg[PCT_W-2:0], 1'b0};
            q_reg   <= {q_reg[PCT_W-2:0], fits};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = q_reg;

endmodule

>>> rtl/stochastic_oscillator_unit.sv
// stochastic oscillator top level: window cell chain, control sequencer, %D averaging
// depends on stoch_pkg, stoch_cell and stoch_div
//
// channel  | dir | tdata (lsb first)                      | tuser (lsb first)
// s_axis   | in  | high_price, low_price, close_price     | -
// m_axis   | out | percent_k, percent_d, 2 zero bits      | k_valid, d_valid, flat_range
//
// one bar at a time: the min/max ripples through the window cells, then the bit-serial %K
// divider runs, and %D, one multiply by the reciprocal, follows once the %D window is full;
// a clipped %K skips the divider, and a flat or filling window gives no %K or %D update
// reset clears control, counts, running sum and held values; the windows fill by use
// a waiting result sits in the output register while the next bar is taken; a second
// result waits in the sequencer and holds off the input until the register frees

module stochastic_oscillator_unit
    import stoch_pkg::*;
#(
    parameter int unsigned WINDOW_K   = 14,
    parameter int unsigned WINDOW_D   = 3,
    parameter int unsigned PRICE_BITS = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // high_price, low_price, close_price
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // percent_k, percent_d, zero pad
    output logic [OUT_USER_W-1:0] m_tuser    // k_valid, d_valid, flat_range
);

    localparam int unsigned PB      = PRICE_BITS;
    localparam int unsigned PROD_W  = PRICE_BITS + SCALE_W;
    localparam int unsigned SCAN_W  = $clog2(WINDOW_K);
    localparam int unsigned BARS_W  = $clog2(WINDOW_K + 1);
    localparam int unsigned ENT_W   = $clog2(WINDOW_D + 1);
    localparam int unsigned SUM_W   = PCT_W + $clog2(WINDOW_D) + 1;
    localparam int unsigned D_SHIFT = SUM_W + $clog2(WINDOW_D);
    localparam int unsigned RECIP_W = SUM_W + 1;
    localparam int unsigned DPROD_W = SUM_W + RECIP_W;
    localparam longint unsigned D_RECIP = ((64'd1 << D_SHIFT) + WINDOW_D - 1) / WINDOW_D;

    state_t state_reg;
    state_t state_next;

    logic              in_xfer;
    logic              out_load;
    logic [PB-1:0]     high_in;
    logic [PB-1:0]     low_in;
    logic [PB-1:0]     close_in;

    logic [PB-1:0]     high_chain [WINDOW_K+1];
    logic [PB-1:0]     low_chain  [WINDOW_K+1];
    logic [PB-1:0]     min_chain  [WINDOW_K+1];
    logic [PB-1:0]     max_chain  [WINDOW_K+1];

    logic [SCAN_W-1:0] scan_cnt_reg;
    logic [BARS_W-1:0] bars_seen_reg;
    logic [ENT_W-1:0]  k_entries_reg;
    logic [SUM_W-1:0]  k_sum_reg;
    logic [PCT_W-1:0]  held_k_reg;
    logic [PCT_W-1:0]  held_d_reg;
    logic              k_flag_reg;
    logic              d_flag_reg;
    logic              flat_flag_reg;
    logic              m_tvalid_reg;

    logic [PB-1:0]     close_reg;
    logic [PB-1:0]     num_reg;
    logic [PB-1:0]     den_reg;
    logic [PCT_W-1:0]  k_val_reg;
    logic [PCT_W-1:0]  k_store_reg [WINDOW_D];
    logic [OUT_DATA_W-1:0] m_tdata_reg;
    logic [OUT_USER_W-1:0] m_tuser_reg;

    logic [PB-1:0]     lowest;
    logic [PB-1:0]     highest;
    logic              win_full;
    logic              range_flat;
    logic              k_zero;
    logic              k_full;
    logic [PB-1:0]     num_c;
    logic [PB-1:0]     den_c;
    logic              d_full_after;
    logic              d_window_full;

    logic [PROD_W-1:0]  prod;
    logic [DPROD_W-1:0] d_prod;
    logic [PCT_W-1:0]   d_avg;
    logic               div_start;
    logic [PB-1:0]      div_init;
    logic [PCT_W-1:0]   div_lo;
    logic [PB-1:0]      div_den;
    div_stat_t          div_stat;
    logic [PCT_W-1:0]   div_q;

    assign s_tready = state_reg == ST_IDLE;
    assign in_xfer  = s_tvalid && s_tready;
    assign out_load = (state_reg == ST_OUT) && (!m_tvalid_reg || m_tready);

    assign high_in  = PB'(s_tdata[IN_FIELD_W-1:0]);
    assign low_in   = PB'(s_tdata[2*IN_FIELD_W-1:IN_FIELD_W]);
    assign close_in = PB'(s_tdata[3*IN_FIELD_W-1:2*IN_FIELD_W]);

    // window chain, newest bar in the first cell
    assign high_chain[0] = high_in;
    assign low_chain[0]  = low_in;
    assign min_chain[0]  = '1;
    assign max_chain[0]  = '0;

    for (genvar i = 0; i < WINDOW_K; i++)
    begin : g_cell
        stoch_cell #(
            .PRICE_BITS (PRICE_BITS)
        ) u_cell (
            .clk      (clk),
            .shift_en (in_xfer),
            .high_in  (high_chain[i]),
            .low_in   (low_chain[i]),
            .min_in   (min_chain[i]),
            .max_in   (max_chain[i]),
            .high_q   (high_chain[i+1]),
            .low_q    (low_chain[i+1]),
            .min_q    (min_chain[i+1]),
            .max_q    (max_chain[i+1])
        );
    end

    assign lowest     = min_chain[WINDOW_K];
    assign highest    = max_chain[WINDOW_K];
    assign win_full   = bars_seen_reg == BARS_W'(WINDOW_K);
    assign range_flat = highest == lowest;

    always_comb
    begin
        if (highest > lowest)
        begin
            den_c  = highest - lowest;
            num_c  = close_reg - lowest;
            k_zero = close_reg <= lowest;
            k_full = !k_zero && (close_reg >= highest);
        end
        else
        begin
            den_c  = lowest - highest;
            num_c  = lowest - close_reg;
            k_zero = close_reg >= lowest;
            k_full = !k_zero && (num_c >= den_c);
        end
    end

    assign d_window_full = k_entries_reg == ENT_W'(WINDOW_D);
    assign d_full_after  = d_window_full || (k_entries_reg == ENT_W'(WINDOW_D - 1));

    // %D: running sum times the rounded-up reciprocal of the window length
    assign d_prod = DPROD_W'(k_sum_reg) * DPROD_W'(D_RECIP);
    assign d_avg  = PCT_W'(d_prod >> D_SHIFT);

    // %K divider: (num * 100) << 16 / den
    assign prod      = PROD_W'(num_reg) * PROD_W'(PCT_SCALE);
    assign div_start = state_reg == ST_MUL;
    assign div_init  = PB'(prod >> SCALE_W);
    assign div_lo    = {prod[SCALE_W-1:0], {FRAC_W{1'b0}}};
    assign div_den   = den_reg;

    stoch_div #(
        .DEN_W (PRICE_BITS)
    ) u_div (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (div_start),
        .init_rem    (div_init),
        .dividend_lo (div_lo),
        .den         (div_den),
        .stat        (div_stat),
        .quotient    (div_q)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                    state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (scan_cnt_reg == SCAN_W'(WINDOW_K - 1))
                    state_next = ST_PREP;
            end
            ST_PREP:
            begin
                if (!win_full || range_flat)
                    state_next = ST_OUT;
                else if (k_zero || k_full)
                    state_next = ST_KUPD;
                else
                    state_next = ST_MUL;
            end
            ST_MUL:
            begin
                state_next = ST_KDIV;
            end
            ST_KDIV:
            begin
                if (div_stat.done)
                    state_next = ST_KUPD;
            end
            ST_KUPD:
            begin
                state_next = d_full_after ? ST_DAVG : ST_OUT;
            end
            ST_DAVG:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_load)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            scan_cnt_reg  <= '0;
            bars_seen_reg <= '0;
            k_entries_reg <= '0;
            k_sum_reg     <= '0;
            held_k_reg    <= '0;
            held_d_reg    <= '0;
            k_flag_reg    <= 1'b0;
            d_flag_reg    <= 1'b0;
            flat_flag_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (in_xfer)
            begin
                scan_cnt_reg  <= '0;
                k_flag_reg    <= 1'b0;
                d_flag_reg    <= 1'b0;
                flat_flag_reg <= 1'b0;
                if (!win_full)
                    bars_seen_reg <= bars_seen_reg + 1'b1;
            end
            else if (state_reg == ST_SCAN)
            begin
                scan_cnt_reg <= scan_cnt_reg + 1'b1;
            end

            if ((state_reg == ST_PREP) && win_full && range_flat)
                flat_flag_reg <= 1'b1;

            if (state_reg == ST_KUPD)
            begin
                held_k_reg <= k_val_reg;
                k_flag_reg <= 1'b1;
                if (d_window_full)
                    k_sum_reg <= k_sum_reg - SUM_W'(k_store_reg[WINDOW_D-1])
                                 + SUM_W'(k_val_reg);
                else
                begin
                    k_sum_reg     <= k_sum_reg + SUM_W'(k_val_reg);
                    k_entries_reg <= k_entries_reg + 1'b1;
                end
            end

            if (state_reg == ST_DAVG)
            begin
                held_d_reg <= d_avg;
                d_flag_reg <= 1'b1;
            end

            if (out_load)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
            close_reg <= close_in;

        if (state_reg == ST_PREP)
        begin
            num_reg   <= num_c;
            den_reg   <= den_c;
            k_val_reg <= k_full ? K_FULL_SCALE : '0;
        end

        if ((state_reg == ST_KDIV) && div_stat.done)
            k_val_reg <= div_q;

        if (state_reg == ST_KUPD)
        begin
            k_store_reg[0] <= k_val_reg;
            for (int j = 1; j < WINDOW_D; j++)
                k_store_reg[j] <= k_store_reg[j-1];
        end

        if (out_load)
        begin
            m_tdata_reg <= {{(OUT_DATA_W - 2*PCT_W){1'b0}}, held_d_reg, held_k_reg};
            m_tuser_reg <= {flat_flag_reg, d_flag_reg, k_flag_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    a_div_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider restarted while busy");

    a_k_or_flat: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tuser[0] && m_tuser[2]))
        else $error("k update and flat range in one result");

    a_d_needs_k: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[1]) |-> m_tuser[0])
        else $error("d update without k update");

    a_k_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[PCT_W-1:0] <= K_FULL_SCALE))
        else $error("percent k above full scale");

endmodule

>>> verif/stochastic_oscillator_unit_test.sv
// testbench for stochastic_oscillator_unit: price bar transfers in, %K/%D results checked
// against a built-in predictor of the 14-bar %K and 3-value %D windows
// depends on stoch_pkg and the stochastic_oscillator_unit rtl

module stochastic_oscillator_unit_test
    import stoch_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned WIN_K      = 14;
    localparam int unsigned WIN_D      = 3;
    localparam int unsigned PRICE_W    = 32;
    localparam int          RANDOM_BARS = 600;
    localparam int          LONG_HOLD   = 400;
    localparam int          IDLE_LIMIT  = 3000;
    localparam int          TAIL_CYCLES = 150;

    typedef enum int {
        RUN_NORMAL,
        RUN_INVERTED,
        RUN_FLAT,
        RUN_WIDE,
        RUN_EXTREME
    } run_kind_t;

    typedef struct packed {
        logic             k_valid;
        logic [PCT_W-1:0] percent_k;
        logic             d_valid;
        logic [PCT_W-1:0] percent_d;
        logic             flat_range;
    } osc_result_t;

    class osc_scoreboard;
        logic [PRICE_W-1:0] high_win [WIN_K];
        logic [PRICE_W-1:0] low_win [WIN_K];
        int                 bar_count;
        logic [PCT_W-1:0]   k_win [WIN_D];
        longint unsigned    k_sum;
        int                 k_count;
        logic [PCT_W-1:0]   last_k;
        logic [PCT_W-1:0]   last_d;
        osc_result_t        pending [$];
        int                 errors;

        function new();
            bar_count = 0;
            k_sum     = 0;
            k_count   = 0;
            last_k    = '0;
            last_d    = '0;
            errors    = 0;
        endfunction

        function logic [PCT_W-1:0] scaled_ratio(longint unsigned num, longint unsigned den);
            longint unsigned prod = num * 100;
            longint unsigned ip   = prod / den;
            longint unsigned rem  = prod % den;
            longint unsigned q    = (ip << FRAC_W) + ((rem << FRAC_W) / den);
            if (q > K_FULL_SCALE)
                q = K_FULL_SCALE;
            return q[PCT_W-1:0];
        endfunction

        function logic [PCT_W-1:0] percent_k_of(longint unsigned cl, longint unsigned lowest,
                                                longint unsigned highest);
            if (highest > lowest)
            begin
                if (cl <= lowest)
                    return '0;
                if (cl >= highest)
                    return K_FULL_SCALE;
                return scaled_ratio(cl - lowest, highest - lowest);
            end
            if (cl >= lowest)
                return '0;
            if (lowest - cl >= lowest - highest)
                return K_FULL_SCALE;
            return scaled_ratio(lowest - cl, lowest - highest);
        endfunction

        function void note_bar(logic [PRICE_W-1:0] hi, logic [PRICE_W-1:0] lo,
                               logic [PRICE_W-1:0] cl);
            osc_result_t        res;
            logic [PRICE_W-1:0] lowest;
            logic [PRICE_W-1:0] highest;
            logic [PCT_W-1:0]   k;
            res = '0;
            for (int i = WIN_K - 1; i > 0; i--)
            begin
                high_win[i] = high_win[i-1];
                low_win[i]  = low_win[i-1];
            end
            high_win[0] = hi;
            low_win[0]  = lo;
            if (bar_count < WIN_K)
                bar_count++;
            if (bar_count >= WIN_K)
            begin
                lowest  = low_win[0];
                highest = high_win[0];
                for (int i = 1; i < WIN_K; i++)
                begin
                    if (low_win[i] < lowest)
                        lowest = low_win[i];
                    if (high_win[i] > highest)
                        highest = high_win[i];
                end
                if (highest == lowest)
                    res.flat_range = 1'b1;
                else
                begin
                    k = percent_k_of(cl, lowest, highest);
                    last_k = k;
                    res.k_valid = 1'b1;
                    if (k_count >= WIN_D)
                        k_sum -= k_win[WIN_D-1];
                    else
                        k_count++;
                    for (int i = WIN_D - 1; i > 0; i--)
                        k_win[i] = k_win[i-1];
                    k_win[0] = k;
                    k_sum += k;
                    if (k_count >= WIN_D)
                    begin
                        last_d = PCT_W'(k_sum / WIN_D);
                        res.d_valid = 1'b1;
                    end
                end
            end
            res.percent_k = last_k;
            res.percent_d = last_d;
            pending = {pending, res};
        endfunction

        function void check_result(logic [OUT_DATA_W-1:0] data, logic [OUT_USER_W-1:0] user);
            osc_result_t want;
            if (pending.size() == 0)
            begin
                $error("result transfer with no bar outstanding");
                errors++;
                return;
            end
            want = pending[0];
            pending.delete(0);
            if (user[0] !== want.k_valid)
            begin
                $error("k_valid: expected %0d, actual %0d", want.k_valid, user[0]);
                errors++;
            end
            if (data[PCT_W-1:0] !== want.percent_k)
            begin
                $error("percent_k: expected %0d, actual %0d", want.percent_k, data[PCT_W-1:0]);
                errors++;
            end
            if (user[1] !== want.d_valid)
            begin
                $error("d_valid: expected %0d, actual %0d", want.d_valid, user[1]);
                errors++;
            end
            if (data[2*PCT_W-1:PCT_W] !== want.percent_d)
            begin
                $error("percent_d: expected %0d, actual %0d", want.percent_d,
                       data[2*PCT_W-1:PCT_W]);
                errors++;
            end
            if (user[2] !== want.flat_range)
            begin
                $error("flat_range: expected %0d, actual %0d", want.flat_range, user[2]);
                errors++;
            end
        endfunction
    endclass

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;   // high_price, low_price, close_price
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;         // percent_k, percent_d, zero pad
    logic [OUT_USER_W-1:0] m_tuser;         // k_valid, d_valid, flat_range

    osc_scoreboard bar_board = new();
    bit            send_quiet;
    bit            recv_quiet;
    int            results_seen;
    int            idle_cycles = 0;

    stochastic_oscillator_unit #(
        .WINDOW_K   (WIN_K),
        .WINDOW_D   (WIN_D),
        .PRICE_BITS (PRICE_W)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic int draw_gap(ref bit quiet);
        if ($urandom_range(0, 39) == 0)
            quiet = !quiet;
        return quiet ? 0 : $urandom_range(0, 17);
    endfunction

    task automatic send_bar(logic [PRICE_W-1:0] hi, logic [PRICE_W-1:0] lo,
                            logic [PRICE_W-1:0] cl);
        int gap;
        gap = draw_gap(send_quiet);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {cl, lo, hi};
        do
            @(posedge clk);
        while (!s_tready);
        bar_board.note_bar(hi, lo, cl);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (bar_board.pending.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [PRICE_W-1:0] edge_price();
        case ($urandom_range(0, 2))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_run(run_kind_t kind);
        int                 len;
        logic [PRICE_W-1:0] mid;
        logic [PRICE_W-1:0] span;
        logic [PRICE_W-1:0] hi;
        logic [PRICE_W-1:0] lo;
        logic [PRICE_W-1:0] cl;
        len  = $urandom_range(WIN_K, 2 * WIN_K + 2);
        mid  = $urandom_range(32'h0020_0000, 32'hFFDF_FFFF);
        span = $urandom_range(0, 1) ? $urandom_range(1, 15) : $urandom_range(16, 32'h000F_FFFF);
        for (int n = 0; n < len; n++)
        begin
            case (kind)
                RUN_NORMAL:
                begin
                    hi = mid + $urandom_range(0, span);
                    lo = mid - $urandom_range(0, span);
                end
                RUN_INVERTED:
                begin
                    hi = mid - $urandom_range(1, span);
                    lo = mid + $urandom_range(0, span);
                end
                RUN_FLAT:
                begin
                    hi = mid;
                    lo = mid;
                end
                RUN_WIDE:
                begin
                    hi = $urandom;
                    lo = $urandom;
                end
                default:
                begin
                    hi = edge_price();
                    lo = edge_price();
                end
            endcase
            if (kind == RUN_WIDE)
                cl = $urandom;
            else if (kind == RUN_EXTREME)
                cl = edge_price();
            else if (kind == RUN_FLAT && $urandom_range(0, 3) == 0)
                cl = mid;
            else
                cl = mid - span - span / 4 + $urandom_range(0, 2 * span + span / 2);
            send_bar(hi, lo, cl);
        end
    endtask

    // no-progress watchdog
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("stochastic_oscillator_unit_test failed");
            $finish;
        end
    end

    // result side: random stalls plus one long hold so the input backs up
    initial
    begin
        int gap;
        results_seen = 0;
        recv_quiet   = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            gap = draw_gap(recv_quiet);
            if (results_seen == 200)
                gap = LONG_HOLD;
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            bar_board.check_result(m_tdata, m_tuser);
            results_seen++;
        end
    end

    initial
    begin
        int        sent;
        bit        drained_mid;
        run_kind_t kind;
        send_quiet  = 1'b0;
        drained_mid = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // window filling, then clipping at both ends and the full price span
        for (int i = 0; i < WIN_K - 1; i++)
            send_bar(1000 + i, 500 - i, 750);
        send_bar(1000, 500, 0);
        send_bar(1000, 500, 2000);
        send_bar(1000, 500, 487);
        send_bar(1000, 500, 1013);
        send_bar(1000, 500, 750);
        send_bar('1, '0, '1);
        send_bar('1, '0, '0);
        send_bar('1, '0, 32'h7FFF_FFFF);
        send_bar('1, '0, 32'h0000_0001);
        send_bar('0, '1, 32'h8000_0000);
        drain_results();

        sent = 0;
        for (int r = 0; sent < RANDOM_BARS; r++)
        begin
            kind = (r < 5) ? run_kind_t'(r) : run_kind_t'($urandom_range(0, 4));
            send_run(kind);
            if (!drained_mid && r >= 12)
            begin
                drained_mid = 1'b1;
                drain_results();
            end
            sent = results_seen + bar_board.pending.size() - 23;
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (bar_board.errors == 0 && bar_board.pending.size() == 0)
            $display("stochastic_oscillator_unit_test passed");
        else
            $display("stochastic_oscillator_unit_test failed");
        $finish;
    end

endmodule

>>> stochastic_oscillator_unit.f
rtl/stoch_pkg.sv
rtl/stoch_cell.sv
rtl/stoch_div.sv
rtl/stochastic_oscillator_unit.sv
verif/stochastic_oscillator_unit_test.sv
